// File: hdl/wtld_pkg.sv
// ----------------------------------------------------------------------------
// wtld_pkg: shared types and constants for the tape level detector
// Item layouts, operation codes and fixed arithmetic constants.
// ----------------------------------------------------------------------------
package wtld_pkg;

	localparam int unsigned SUM_W = 40;
	localparam int unsigned TICKS_W = 48;
	localparam int unsigned FRAMES_W = 20;

	localparam logic [2:0] OP_TICK = 3'd0;
	localparam logic [2:0] OP_SAMPLE = 3'd1;
	localparam logic [2:0] OP_START = 3'd2;
	localparam logic [2:0] OP_STOP = 3'd3;
	localparam logic [2:0] OP_REWIND = 3'd4;

	localparam logic [1:0] CFG_WIDTH_MODE = 2'd0;
	localparam logic [1:0] CFG_CHANNELS = 2'd1;
	localparam logic [1:0] CFG_DIVIDER = 2'd2;
	localparam logic [1:0] CFG_DATA_SIZE = 2'd3;

	localparam logic [1:0] MODE_U8 = 2'd0;
	localparam logic [1:0] MODE_S16 = 2'd1;

	localparam logic [63:0] LEVEL_THRESHOLD = 64'd140;
	localparam logic [6:0] PCT_FULL = 7'd100;
	localparam logic [FRAMES_W-1:0] FRAMES_MAX = '1;

	typedef struct packed {
		logic [2:0] operation;
		logic [19:0] tick_count;
		logic [31:0] sample_word;
	} in_item_t;

	typedef struct packed {
		logic tape_bit;
		logic [19:0] frames_needed;
		logic [6:0] progress_percent;
		logic finished;
		logic protocol_error;
	} out_item_t;

endpackage

// File: hdl/wav_tape_level_detector_core.sv
// ----------------------------------------------------------------------------
// wav_tape_level_detector_core: PCM tape audio to one input bit
// Sequencer around one shared restoring divider (one quotient bit per cycle).
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// in        input      in_valid/in_ready  wtld_pkg::in_item_t
// out       output     out_valid/out_ready wtld_pkg::out_item_t
// cfg       input      cfg_we             cfg_addr, cfg_wdata
//
// Each item runs on the shared divider: position (48 steps) always, progress (39 steps)
// unless the position is at or past the data end; a tick that requests frames adds 32
// steps, the last channel of a frame adds 40, the last frame of a request 64 more.
// A new item is taken only once the last one is through; in_ready is high only while idle.
// The result sits in an output register, so a new item may enter while it waits.
// arst_n clears the control state and loads the configuration defaults; level bit resets to 1.
module wav_tape_level_detector_core #(
	parameter int MAX_CHANNELS = 8
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input wtld_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output wtld_pkg::out_item_t out_item,
	input logic cfg_we,
	input logic [1:0] cfg_addr,
	input logic [31:0] cfg_wdata
);

	localparam int CH_W = $clog2(MAX_CHANNELS + 1);
	localparam int FSZ_W = CH_W + 3;

	typedef enum logic [3:0] {
		S_IDLE, S_APPLY, S_FDIV, S_FACC, S_ADIV, S_PLOAD, S_PDIV,
		S_TICK, S_NDIV, S_PROG, S_GDIV, S_OUT
	} state_t;

	state_t state_q;

	logic [1:0] mode_q;
	logic [3:0] chan_q;
	logic [15:0] divider_q;
	logic [31:0] data_size_q;

	wtld_pkg::in_item_t item_q;
	logic playing_q, level_q, fin_q, err_q, tick_run_q, f_neg_q;
	logic [wtld_pkg::TICKS_W-1:0] total_ticks_q;
	logic [31:0] data_pos_q;
	logic [wtld_pkg::FRAMES_W-1:0] pending_q, requested_q;
	logic [CH_W-1:0] chan_idx_q;
	logic signed [wtld_pkg::SUM_W-1:0] chan_sum_q;
	logic signed [63:0] avg_sum_q;
	logic [54:0] pos_q;
	logic [6:0] pct_q;
	logic out_valid_q;
	wtld_pkg::out_item_t out_item_q;

	// shared divider
	logic [63:0] dv_quo_q;
	logic [31:0] dv_rem_q, dv_den_q;
	logic [6:0] dv_cnt_q;
	logic [32:0] dv_rem_sh, dv_diff;
	logic dv_ge;

	assign dv_rem_sh = {dv_rem_q, dv_quo_q[63]};
	assign dv_diff = dv_rem_sh - {1'b0, dv_den_q};
	assign dv_ge = dv_rem_sh >= {1'b0, dv_den_q};

	// effective configuration
	logic [CH_W-1:0] ch;
	logic [2:0] bps;
	logic [FSZ_W-1:0] fsz;
	logic [15:0] div_eff;

	always_comb begin
		if (chan_q == '0)
			ch = CH_W'(1);
		else if ({1'b0, chan_q} > 5'(MAX_CHANNELS))
			ch = CH_W'(MAX_CHANNELS);
		else
			ch = CH_W'(chan_q);
		unique case (mode_q)
			wtld_pkg::MODE_U8: bps = 3'd1;
			wtld_pkg::MODE_S16: bps = 3'd2;
			default: bps = 3'd4;
		endcase
		fsz = FSZ_W'(ch) * FSZ_W'(bps);
		div_eff = (divider_q == '0) ? 16'd1 : divider_q;
	end

	// sample decode and accumulate
	logic signed [wtld_pkg::SUM_W-1:0] word_dec, sum_new;
	logic [wtld_pkg::SUM_W-1:0] sum_mag, sum_scaled;
	logic [CH_W:0] idx_next;

	always_comb begin
		unique case (mode_q)
			wtld_pkg::MODE_U8: word_dec = {32'd0, item_q.sample_word[7:0]};
			wtld_pkg::MODE_S16:
				word_dec = {{24{item_q.sample_word[15]}}, item_q.sample_word[15:0]};
			default: word_dec = {{8{item_q.sample_word[31]}}, item_q.sample_word};
		endcase
		sum_new = chan_sum_q + word_dec;
		sum_mag = sum_new[wtld_pkg::SUM_W-1] ? -sum_new : sum_new;
		// truncation toward zero: scale the magnitude, sign back later
		unique case (mode_q)
			wtld_pkg::MODE_U8: sum_scaled = sum_mag;
			wtld_pkg::MODE_S16: sum_scaled = sum_mag >> 8;
			default: sum_scaled = sum_mag >> 16;
		endcase
		idx_next = {1'b0, chan_idx_q} + (CH_W+1)'(1);
	end

	logic signed [63:0] f_val, avg_new;
	logic [63:0] avg_mag;
	logic [31:0] pos_diff;
	logic [38:0] pos_x100;

	always_comb begin
		f_val = f_neg_q ? -$signed(dv_quo_q) : $signed(dv_quo_q);
		avg_new = avg_sum_q + f_val;
		avg_mag = avg_new[63] ? -avg_new : avg_new;
		pos_diff = pos_q[31:0] - data_pos_q;
		pos_x100 = 39'(pos_q[31:0]) * 39'(wtld_pkg::PCT_FULL);
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			chan_q <= 4'd1;
			divider_q <= 16'd81;
			data_size_q <= 32'd1;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				wtld_pkg::CFG_WIDTH_MODE: mode_q <= cfg_wdata[1:0];
				wtld_pkg::CFG_CHANNELS: chan_q <= cfg_wdata[3:0];
				wtld_pkg::CFG_DIVIDER: divider_q <= cfg_wdata[15:0];
				wtld_pkg::CFG_DATA_SIZE: data_size_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			playing_q <= 1'b0;
			level_q <= 1'b1;
			total_ticks_q <= '0;
			data_pos_q <= '0;
			pending_q <= '0;
			requested_q <= '0;
			chan_idx_q <= '0;
			chan_sum_q <= '0;
			avg_sum_q <= '0;
			fin_q <= 1'b0;
			err_q <= 1'b0;
			tick_run_q <= 1'b0;
			f_neg_q <= 1'b0;
			out_valid_q <= 1'b0;
			dv_cnt_q <= '0;
		end else begin
			// S_OUT owns out_valid_q while it loads a result
			if (out_valid_q && out_ready && state_q != S_OUT)
				out_valid_q <= 1'b0;
			if (dv_cnt_q != '0) begin
				dv_cnt_q <= dv_cnt_q - 7'd1;
				dv_rem_q <= dv_ge ? dv_diff[31:0] : dv_rem_sh[31:0];
				dv_quo_q <= {dv_quo_q[62:0], dv_ge};
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						fin_q <= 1'b0;
						err_q <= 1'b0;
						tick_run_q <= 1'b0;
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					state_q <= S_PLOAD;
					unique case (item_q.operation)
						wtld_pkg::OP_TICK: begin
							if (pending_q != '0)
								err_q <= 1'b1;
							else if (!playing_q)
								level_q <= 1'b1;
							else begin
								total_ticks_q <= wtld_pkg::TICKS_W'(total_ticks_q
									+ {28'd0, item_q.tick_count});
								tick_run_q <= 1'b1;
							end
						end
						wtld_pkg::OP_SAMPLE: begin
							if (pending_q == '0)
								err_q <= 1'b1;
							else if (idx_next >= {1'b0, ch}) begin
								f_neg_q <= sum_new[wtld_pkg::SUM_W-1];
								dv_quo_q <= {sum_scaled, 24'd0};
								dv_rem_q <= '0;
								dv_den_q <= 32'(ch);
								dv_cnt_q <= 7'd40;
								state_q <= S_FDIV;
							end else begin
								chan_sum_q <= sum_new;
								chan_idx_q <= idx_next[CH_W-1:0];
							end
						end
						wtld_pkg::OP_START: playing_q <= 1'b1;
						wtld_pkg::OP_STOP: playing_q <= 1'b0;
						wtld_pkg::OP_REWIND: begin
							total_ticks_q <= '0;
							data_pos_q <= '0;
							pending_q <= '0;
							chan_idx_q <= '0;
							chan_sum_q <= '0;
							avg_sum_q <= '0;
						end
						default: err_q <= 1'b1;
					endcase
				end
				S_FDIV: begin
					if (dv_cnt_q == '0)
						state_q <= S_FACC;
				end
				S_FACC: begin
					avg_sum_q <= avg_new;
					data_pos_q <= 32'(data_pos_q + 32'(fsz));
					pending_q <= pending_q - wtld_pkg::FRAMES_W'(1);
					chan_idx_q <= '0;
					chan_sum_q <= '0;
					if (pending_q == wtld_pkg::FRAMES_W'(1)) begin
						dv_quo_q <= avg_mag;
						dv_rem_q <= '0;
						dv_den_q <= (requested_q == '0) ? 32'd1 : 32'(requested_q);
						dv_cnt_q <= 7'd64;
						state_q <= S_ADIV;
					end else
						state_q <= S_PLOAD;
				end
				S_ADIV: begin
					if (dv_cnt_q == '0) begin
						level_q <= dv_quo_q > wtld_pkg::LEVEL_THRESHOLD;
						state_q <= S_PLOAD;
					end
				end
				S_PLOAD: begin
					dv_quo_q <= {total_ticks_q, 16'd0};
					dv_rem_q <= '0;
					dv_den_q <= 32'(div_eff);
					dv_cnt_q <= 7'd48;
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					if (dv_cnt_q == '0) begin
						pos_q <= 55'(dv_quo_q[47:0]) * 55'(fsz);
						state_q <= tick_run_q ? S_TICK : S_PROG;
					end
				end
				S_TICK: begin
					state_q <= S_PROG;
					if (pos_q > {23'd0, data_size_q}) begin
						level_q <= 1'b1;
						playing_q <= 1'b0;
						fin_q <= 1'b1;
					end else if (pos_q > {23'd0, data_pos_q} && pos_diff > 32'(fsz)) begin
						dv_quo_q <= {pos_diff, 32'd0};
						dv_rem_q <= '0;
						dv_den_q <= 32'(fsz);
						dv_cnt_q <= 7'd32;
						state_q <= S_NDIV;
					end
				end
				S_NDIV: begin
					if (dv_cnt_q == '0) begin
						if (dv_quo_q > 64'(wtld_pkg::FRAMES_MAX)) begin
							pending_q <= wtld_pkg::FRAMES_MAX;
							requested_q <= wtld_pkg::FRAMES_MAX;
						end else begin
							pending_q <= dv_quo_q[wtld_pkg::FRAMES_W-1:0];
							requested_q <= dv_quo_q[wtld_pkg::FRAMES_W-1:0];
						end
						chan_idx_q <= '0;
						chan_sum_q <= '0;
						avg_sum_q <= '0;
						state_q <= S_PROG;
					end
				end
				S_PROG: begin
					if (pos_q >= {23'd0, data_size_q}) begin
						pct_q <= wtld_pkg::PCT_FULL;
						state_q <= S_OUT;
					end else begin
						dv_quo_q <= {pos_x100, 25'd0};
						dv_rem_q <= '0;
						dv_den_q <= data_size_q;
						dv_cnt_q <= 7'd39;
						state_q <= S_GDIV;
					end
				end
				S_GDIV: begin
					if (dv_cnt_q == '0) begin
						pct_q <= dv_quo_q[6:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_item_q.tape_bit <= playing_q ? level_q : 1'b1;
						out_item_q.frames_needed <= pending_q;
						out_item_q.progress_percent <= pct_q;
						out_item_q.finished <= fin_q;
						out_item_q.protocol_error <= err_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: sim/tb_wav_tape_level_detector_core.sv
// ----------------------------------------------------------------------------
// tb_wav_tape_level_detector_core: self-checking bench for the tape level detector
// Drives tick, sample and control items with random idling and back-pressure.
// A behavioral level predictor computes each expected result at input
// acceptance, and a monitor compares every output item field by field.
// ----------------------------------------------------------------------------
module tb_wav_tape_level_detector_core;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wtld_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wtld_pkg::out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_addr = '0;
	logic [31:0] cfg_wdata = '0;

	wav_tape_level_detector_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// level predictor: configuration and playback state
	logic [1:0] lv_mode = wtld_pkg::MODE_U8;
	logic [3:0] lv_chans = 4'd1;
	logic [15:0] lv_div = 16'd81;
	logic [31:0] lv_size = 32'd1;
	bit lv_playing = 0;
	bit lv_level = 1;
	logic [47:0] lv_ticks = '0;
	logic [31:0] lv_consumed = '0;
	int unsigned lv_pending = 0;
	int unsigned lv_requested = 0;
	int unsigned lv_chan_idx = 0;
	longint lv_chan_acc = 0;
	longint lv_frame_acc = 0;

	wtld_pkg::out_item_t level_results[$];
	int mismatches = 0;
	bit no_idle = 0;
	int hold_req = 0;

	function automatic int unsigned eff_chans();
		if (lv_chans == 0) return 1;
		if (lv_chans > 8) return 8;
		return 32'(lv_chans);
	endfunction

	function automatic int unsigned sample_bytes();
		return lv_mode == wtld_pkg::MODE_U8 ? 1 : (lv_mode == wtld_pkg::MODE_S16 ? 2 : 4);
	endfunction

	function automatic longint unsigned tape_pos();
		longint unsigned d;
		d = (lv_div == 0) ? 64'd1 : 64'(lv_div);
		return ({16'b0, lv_ticks} / d) * 64'(sample_bytes() * eff_chans());
	endfunction

	function automatic longint decode_sample(logic [31:0] w);
		if (lv_mode == wtld_pkg::MODE_U8) return longint'(w[7:0]);
		if (lv_mode == wtld_pkg::MODE_S16) return longint'($signed(w[15:0]));
		return longint'($signed(w));
	endfunction

	task automatic predict_level(input wtld_pkg::in_item_t it);
		wtld_pkg::out_item_t r;
		longint unsigned pos, fsz, diff, n;
		longint f, a;
		int unsigned ch;
		r = '0;
		case (it.operation)
			wtld_pkg::OP_TICK: begin
				if (lv_pending != 0) r.protocol_error = 1;
				else if (!lv_playing) lv_level = 1;
				else begin
					lv_ticks = lv_ticks + it.tick_count;
					pos = tape_pos();
					if (pos > lv_size) begin
						lv_level = 1;
						lv_playing = 0;
						r.finished = 1;
					end else if (pos > lv_consumed) begin
						fsz = 64'(sample_bytes() * eff_chans());
						diff = pos - lv_consumed;
						if (diff > fsz) begin
							n = diff / fsz;
							if (n > 1048575) n = 1048575;
							lv_pending = 32'(n);
							lv_requested = 32'(n);
							lv_chan_idx = 0;
							lv_chan_acc = 0;
							lv_frame_acc = 0;
						end
					end
				end
			end
			wtld_pkg::OP_SAMPLE: begin
				if (lv_pending == 0) r.protocol_error = 1;
				else begin
					ch = eff_chans();
					lv_chan_acc += decode_sample(it.sample_word);
					lv_chan_idx++;
					if (lv_chan_idx >= ch) begin
						f = lv_chan_acc;
						if (lv_mode == wtld_pkg::MODE_S16) f = f / 256;
						else if (lv_mode != wtld_pkg::MODE_U8) f = f / 65536;
						f = f / longint'(ch);
						lv_frame_acc += f;
						lv_consumed = lv_consumed + ch * sample_bytes();
						lv_chan_idx = 0;
						lv_chan_acc = 0;
						lv_pending--;
						if (lv_pending == 0) begin
							a = lv_frame_acc / longint'(lv_requested ? lv_requested : 1);
							if (a < 0) a = -a;
							lv_level = a > 140;
						end
					end
				end
			end
			wtld_pkg::OP_START: lv_playing = 1;
			wtld_pkg::OP_STOP: lv_playing = 0;
			wtld_pkg::OP_REWIND: begin
				lv_ticks = '0;
				lv_consumed = '0;
				lv_pending = 0;
				lv_chan_idx = 0;
				lv_chan_acc = 0;
				lv_frame_acc = 0;
			end
			default: r.protocol_error = 1;
		endcase
		pos = tape_pos();
		r.tape_bit = lv_playing ? lv_level : 1'b1;
		r.frames_needed = lv_pending[19:0];
		r.progress_percent = (pos >= lv_size) ? 7'd100 : 7'(pos * 100 / lv_size);
		level_results.push_back(r);
	endtask

	// receiver: random stalls, or a counted hold-off when requested
	int hold_cnt = 0;
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_cnt = hold_req;
			hold_req = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 32);
		end
	end

	always @(posedge clk) begin
		wtld_pkg::out_item_t e;
		if (out_valid && out_ready) begin
			if (level_results.size() == 0) begin
				$error("unexpected result item %p", out_item);
				mismatches++;
			end else begin
				e = level_results.pop_front();
				if (out_item.tape_bit !== e.tape_bit) begin
					$error("tape_bit: expected %0d, got %0d", e.tape_bit, out_item.tape_bit);
					mismatches++;
				end
				if (out_item.frames_needed !== e.frames_needed) begin
					$error("frames_needed: expected %0d, got %0d",
						e.frames_needed, out_item.frames_needed);
					mismatches++;
				end
				if (out_item.progress_percent !== e.progress_percent) begin
					$error("progress_percent: expected %0d, got %0d",
						e.progress_percent, out_item.progress_percent);
					mismatches++;
				end
				if (out_item.finished !== e.finished) begin
					$error("finished: expected %0d, got %0d", e.finished, out_item.finished);
					mismatches++;
				end
				if (out_item.protocol_error !== e.protocol_error) begin
					$error("protocol_error: expected %0d, got %0d",
						e.protocol_error, out_item.protocol_error);
					mismatches++;
				end
			end
		end
	end

	task automatic send_item(input logic [2:0] op, input logic [19:0] ticks,
			input logic [31:0] word);
		wtld_pkg::in_item_t it;
		it.operation = op;
		it.tick_count = ticks;
		it.sample_word = word;
		if (!no_idle && $urandom_range(99) < 32) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		predict_level(it);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (level_results.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			wtld_pkg::CFG_WIDTH_MODE: lv_mode = val[1:0];
			wtld_pkg::CFG_CHANNELS: lv_chans = val[3:0];
			wtld_pkg::CFG_DIVIDER: lv_div = val[15:0];
			default: lv_size = val;
		endcase
	endtask

	task automatic set_format(input logic [1:0] m, input logic [3:0] c,
			input logic [15:0] d, input logic [31:0] s);
		write_reg(wtld_pkg::CFG_WIDTH_MODE, 32'(m));
		write_reg(wtld_pkg::CFG_CHANNELS, 32'(c));
		write_reg(wtld_pkg::CFG_DIVIDER, 32'(d));
		write_reg(wtld_pkg::CFG_DATA_SIZE, s);
	endtask

	function automatic logic [31:0] pick_sample();
		int v;
		if ($urandom_range(1)) return $urandom;
		v = int'($urandom_range(400)) - 200;
		if (lv_mode == wtld_pkg::MODE_U8) v = v + 128;
		else if (lv_mode == wtld_pkg::MODE_S16) v = v * 256;
		else v = v * 65536;
		return v;
	endfunction

	task automatic test_reset_state();
		send_item(wtld_pkg::OP_TICK, 20'd100, '0);   // stopped: level forced high
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'hFFFF_FFFF);
		send_item(3'd5, '1, '0);
		send_item(3'd6, '0, '0);
		send_item(3'd7, '1, '1);
		send_item(wtld_pkg::OP_START, '0, '0);
		send_item(wtld_pkg::OP_TICK, 20'd80, '0);
		send_item(wtld_pkg::OP_TICK, 20'd1, '0);    // one frame at the end
		send_item(wtld_pkg::OP_TICK, 20'd200, '0);  // past the end
	endtask

	task automatic test_directed_ops();
		set_format(wtld_pkg::MODE_S16, 4'd2, 16'd10, 32'd1000);
		send_item(wtld_pkg::OP_START, '0, '0);
		send_item(wtld_pkg::OP_TICK, 20'd35, '0);   // three frames of two channels
		send_item(wtld_pkg::OP_TICK, 20'd5, '0);    // tick while frames pending
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h0000_7FFF);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h0000_7FFF);
		send_item(wtld_pkg::OP_STOP, '0, '0);       // stop keeps the collection
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h0000_8000);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h0000_8000);
		send_item(wtld_pkg::OP_START, '0, '0);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h1234_7FFF);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h0000_7000);
		send_item(wtld_pkg::OP_TICK, 20'd20, '0);
		send_item(wtld_pkg::OP_REWIND, '0, '0);     // abandons the request
		send_item(wtld_pkg::OP_TICK, '1, '0);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
	endtask

	task automatic test_odd_config();
		set_format(2'd3, 4'd0, 16'd0, 32'd0);
		send_item(wtld_pkg::OP_START, '0, '0);
		send_item(wtld_pkg::OP_TICK, 20'd1, '0);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
		send_item(wtld_pkg::OP_TICK, 20'd3, '0);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h8000_0000);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'h7FFF_FFFF);
		set_format(wtld_pkg::MODE_U8, 4'd15, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
		send_item(wtld_pkg::OP_TICK, '1, '0);
		send_item(wtld_pkg::OP_TICK, '1, '0);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
	endtask

	// request beyond the frames_needed range
	task automatic test_saturation();
		set_format(wtld_pkg::MODE_U8, 4'd1, 16'd1, 32'hFFFF_FFFF);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
		send_item(wtld_pkg::OP_START, '0, '0);
		send_item(wtld_pkg::OP_TICK, 20'd1, '0);
		send_item(wtld_pkg::OP_TICK, '1, '0);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'd255);
		send_item(wtld_pkg::OP_SAMPLE, '0, 32'd0);
		send_item(wtld_pkg::OP_REWIND, '0, '0);
	endtask

	task automatic run_random(input int count);
		int k;
		int r;
		int unsigned dv;
		for (k = 0; k < count; k++) begin
			dv = lv_div == 0 ? 1 : lv_div;
			r = $urandom_range(99);
			if (lv_pending != 0) begin
				if (r < 94) send_item(wtld_pkg::OP_SAMPLE, 20'($urandom), pick_sample());
				else if (r < 96) send_item(wtld_pkg::OP_TICK, 20'($urandom), $urandom);
				else if (r < 97)
					send_item(3'($urandom_range(5, 7)), 20'($urandom), $urandom);
				else if (r < 98) send_item(wtld_pkg::OP_STOP, 20'($urandom), $urandom);
				else if (r < 99) send_item(wtld_pkg::OP_START, 20'($urandom), $urandom);
				else send_item(wtld_pkg::OP_REWIND, 20'($urandom), $urandom);
			end else if (!lv_playing && r < 60) begin
				if (r < 15) send_item(wtld_pkg::OP_REWIND, 20'($urandom), $urandom);
				send_item(wtld_pkg::OP_START, 20'($urandom), $urandom);
			end else begin
				if (r < 75)
					send_item(wtld_pkg::OP_TICK,
						20'(dv * $urandom_range(0, 5) + $urandom_range(dv)), $urandom);
				else if (r < 80) send_item(wtld_pkg::OP_TICK, 20'($urandom), $urandom);
				else if (r < 85) send_item(wtld_pkg::OP_SAMPLE, 20'($urandom), $urandom);
				else if (r < 88)
					send_item(3'($urandom_range(5, 7)), 20'($urandom), $urandom);
				else if (r < 92) send_item(wtld_pkg::OP_STOP, 20'($urandom), $urandom);
				else if (r < 96) send_item(wtld_pkg::OP_REWIND, 20'($urandom), $urandom);
				else send_item(wtld_pkg::OP_START, 20'($urandom), $urandom);
			end
		end
	endtask

	task automatic test_random();
		set_format(wtld_pkg::MODE_U8, 4'd1, 16'd3, 32'd2000);
		run_random(300);
		set_format(wtld_pkg::MODE_S16, 4'd2, 16'd7, 32'd5000);
		no_idle = 1;
		run_random(250);
		no_idle = 0;
		set_format(2'd2, 4'd8, 16'd1, 32'd4000);
		run_random(300);
		set_format(wtld_pkg::MODE_S16, 4'd8, 16'hFFFF, 32'd100000);
		run_random(250);
		set_format(2'd3, 4'd15, 16'd0, 32'd3000);
		run_random(250);
		set_format(wtld_pkg::MODE_U8, 4'd3, 16'd20, 32'd600);
		run_random(300);
	endtask

	// receiver holds off while items keep coming, then sender waits for all
	task automatic test_backpressure();
		set_format(wtld_pkg::MODE_S16, 4'd1, 16'd5, 32'd100000);
		hold_req = 800;
		run_random(40);
		drain();
		run_random(40);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_state();
		test_directed_ops();
		test_odd_config();
		test_saturation();
		test_backpressure();
		test_random();
		drain();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
hdl/wtld_pkg.sv
hdl/wav_tape_level_detector_core.sv
sim/tb_wav_tape_level_detector_core.sv
